// ===== sv/ptc_pkg.sv =====
// ----------------------------------------------------------------------------
// ptc_pkg: shared types and constants of pressure/temperature compensation
// Payload structs, configuration register indexes and the fixed constants of
// the integer compensation arithmetic.
// ----------------------------------------------------------------------------
package ptc_pkg;

  // configuration register indexes
  typedef enum logic [7:0] {
    CFG_TEMP     = 8'd0,
    CFG_PRESS_A  = 8'd1,
    CFG_PRESS_B  = 8'd2,
    CFG_PRESS_P9 = 8'd3
  } cfg_idx_t;

  localparam int CfgIdxW     = 8;
  localparam int DivStages   = 64;
  localparam int TfOffset    = 128000;
  localparam int PressBase   = 1048576;
  localparam int DivScale    = 3125;
  localparam int TcRound     = 128;
  localparam int TcMax       = 8388607;
  localparam int TcMin       = -8388608;
  localparam int OffsetShift = 47;
  localparam int DivShift    = 33;
  localparam int PressShift  = 31;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
  } in_t;

  typedef struct packed {
    logic signed [23:0] temperature_centideg;
    logic signed [31:0] fine_temperature;
    logic [31:0]        pressure_q24_8;
    logic               pressure_valid;
  } out_t;

  // temperature results and divisor flag carried alongside the pressure path
  typedef struct packed {
    logic signed [23:0] tc;
    logic signed [31:0] tf;
    logic               pvalid;
  } side_t;

endpackage

// ===== sv/ptc_mul64.sv =====
// ----------------------------------------------------------------------------
// ptc_mul64: registered 64-bit modular multiplier
// Low 64 bits of a 64 x 64 product from three 32 x 32 partial products,
// summed and registered in one stage.
// ----------------------------------------------------------------------------
module ptc_mul64 (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p
);

  logic [63:0] ll;
  logic [31:0] lh;
  logic [31:0] hl;
  logic [63:0] p_r;

  // form partial products; cross terms only matter in their low half
  assign ll = {32'd0, a[31:0]} * {32'd0, b[31:0]};
  assign lh = a[31:0] * b[63:32];
  assign hl = a[63:32] * b[31:0];

  // sum and hold the product
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= ll + {lh + hl, 32'd0};
    end
  end

  assign p = p_r;

endmodule

// ===== sv/ptc_div.sv =====
// ----------------------------------------------------------------------------
// ptc_div: pipelined signed 64-bit divider
// Sign strip, one restoring step per stage over 64 stages, sign restore.
// Quotient truncates toward zero; the divisor magnitude stays below 2^31.
// ----------------------------------------------------------------------------
module ptc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_v,
  input  logic [63:0]       num,
  input  logic [63:0]       den,
  input  ptc_pkg::side_t    side_in,
  output logic              out_v,
  output logic [63:0]       quot,
  output ptc_pkg::side_t    side_out
);

  localparam int N = ptc_pkg::DivStages;

  logic [63:0]    q_r    [0:N];
  logic [31:0]    rem_r  [0:N];
  logic [31:0]    ad_r   [0:N];
  logic           neg_r  [0:N];
  ptc_pkg::side_t side_r [0:N];
  logic           v_r    [0:N];

  logic [63:0] an;
  logic [63:0] adw;
  logic        out_v_r;
  logic [63:0] quot_r;
  ptc_pkg::side_t side_out_r;

  // strip signs
  assign an  = num[63] ? (64'd0 - num) : num;
  assign adw = den[63] ? (64'd0 - den) : den;

  always_ff @(posedge clk) begin
    if (en) begin
      q_r[0]    <= an;
      rem_r[0]  <= 32'd0;
      ad_r[0]   <= adw[31:0];
      neg_r[0]  <= num[63] ^ den[63];
      side_r[0] <= side_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
    end
  end

  // one quotient bit per stage
  for (genvar k = 0; k < N; k++) begin : g_step
    logic [31:0] sh;
    logic [32:0] diff;
    logic        ge;

    assign sh   = {rem_r[k][30:0], q_r[k][63]};
    assign diff = {1'b0, sh} - {1'b0, ad_r[k]};
    assign ge   = !diff[32];

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= ge ? diff[31:0] : sh;
        q_r[k+1]    <= {q_r[k][62:0], ge};
        ad_r[k+1]   <= ad_r[k];
        neg_r[k+1]  <= neg_r[k];
        side_r[k+1] <= side_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end
  end

  // restore the sign
  always_ff @(posedge clk) begin
    if (en) begin
      quot_r     <= neg_r[N] ? (64'd0 - q_r[N]) : q_r[N];
      side_out_r <= side_r[N];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= v_r[N];
    end
  end

  assign out_v    = out_v_r;
  assign quot     = quot_r;
  assign side_out = side_out_r;

endmodule

// ===== sv/pressure_temperature_compensation.sv =====
// ----------------------------------------------------------------------------
// pressure_temperature_compensation: barometer integer compensation
// Temperature stage, 64-bit wrapping pressure stage and pipelined division.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle; the whole pipeline, including the
// 64-stage divider, advances together and holds only while a result waits.
// Reset clears all valid bits and the four calibration registers to zero.
module pressure_temperature_compensation (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  ptc_pkg::in_t                     in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output ptc_pkg::out_t                    out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ptc_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [63:0]                      cfg_data
);

  logic en;

  // calibration registers
  logic [47:0] temp_cal_r;
  logic [63:0] press_a_r;
  logic [63:0] press_b_r;
  logic [15:0] press_p9_r;

  // unpacked coefficients
  logic [15:0]        t1;
  logic signed [15:0] t2, t3;
  logic [15:0]        p1;
  logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;
  logic [63:0]        p2x, p3x, p4x, p5x, p6x, p7x, p8x, p9x;

  // temperature stages
  logic signed [17:0] dt1;
  logic signed [16:0] dt2;
  logic signed [33:0] ta_s1_r, dd_s1_r;
  logic [19:0]        adcp_s1_r;
  logic               v_s1_r;
  logic signed [21:0] ddsh;
  logic signed [22:0] at_s2_r;
  logic signed [37:0] bt_s2_r;
  logic [19:0]        adcp_s2_r;
  logic               v_s2_r;
  logic signed [31:0] tf_s3_r;
  logic [19:0]        adcp_s3_r;
  logic               v_s3_r;

  // pressure stages
  logic signed [34:0] tc_w;
  logic signed [26:0] tc_sh;
  logic signed [23:0] tc_sat;
  logic signed [23:0] tc_s4_r, tc_s5_r, tc_s6_r, tc_s7_r, tc_s8_r;
  logic signed [31:0] tf_s4_r, tf_s5_r, tf_s6_r, tf_s7_r, tf_s8_r;
  logic [19:0]        adcp_s4_r, adcp_s5_r, adcp_s6_r, adcp_s7_r;
  logic               v_s4_r, v_s5_r, v_s6_r, v_s7_r, v_s8_r, v_s9_r;
  logic [63:0]        a_s4_r;
  logic [63:0]        aa_s5, ap5_s5, ap2_s5;
  logic [63:0]        aap6_s6, aap3_s6, bpart_s6_r, ap2sh_s6_r;
  logic [63:0]        aap3_sh;
  logic [63:0]        b_s7_r, x_s7_r;
  logic [63:0]        pr;
  logic [63:0]        m_s8, n_s8_r;
  logic [63:0]        mshift;
  logic [63:0]        nn_s9, den_s9_r;
  ptc_pkg::side_t     side_s9_r;

  // divider output and tail
  logic               div_v;
  logic [63:0]        div_q;
  ptc_pkg::side_t     div_side;
  logic [63:0]        qs;
  logic [63:0]        ps_e1, pb_e1, qs_e1_r, q_e1_r;
  ptc_pkg::side_t     side_e1_r, side_e2_r, side_e3_r;
  logic               v_e1_r, v_e2_r, v_e3_r;
  logic [63:0]        a_e2, pb_e2_r, q_e2_r;
  logic [63:0]        a_sh, pb_sh;
  logic [63:0]        sum_e3_r;
  logic [63:0]        sum_sh, res;
  logic [31:0]        press_sat;
  logic               out_valid_r;
  ptc_pkg::out_t      out_data_r;

  // advance everything unless a finished result is held
  assign en        = !(out_valid_r && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  // write calibration registers; ignore unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_cal_r <= '0;
      press_a_r  <= '0;
      press_b_r  <= '0;
      press_p9_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ptc_pkg::CFG_TEMP:     temp_cal_r <= cfg_data[47:0];
        ptc_pkg::CFG_PRESS_A:  press_a_r  <= cfg_data;
        ptc_pkg::CFG_PRESS_B:  press_b_r  <= cfg_data;
        ptc_pkg::CFG_PRESS_P9: press_p9_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // slice coefficients
  assign t1  = temp_cal_r[15:0];
  assign t2  = temp_cal_r[31:16];
  assign t3  = temp_cal_r[47:32];
  assign p1  = press_a_r[15:0];
  assign p2  = press_a_r[31:16];
  assign p3  = press_a_r[47:32];
  assign p4  = press_a_r[63:48];
  assign p5  = press_b_r[15:0];
  assign p6  = press_b_r[31:16];
  assign p7  = press_b_r[47:32];
  assign p8  = press_b_r[63:48];
  assign p9  = press_p9_r;
  assign p2x = 64'(p2);
  assign p3x = 64'(p3);
  assign p4x = 64'(p4);
  assign p5x = 64'(p5);
  assign p6x = 64'(p6);
  assign p7x = 64'(p7);
  assign p8x = 64'(p8);
  assign p9x = 64'(p9);

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_s1_r      <= 1'b0;
      v_s2_r      <= 1'b0;
      v_s3_r      <= 1'b0;
      v_s4_r      <= 1'b0;
      v_s5_r      <= 1'b0;
      v_s6_r      <= 1'b0;
      v_s7_r      <= 1'b0;
      v_s8_r      <= 1'b0;
      v_s9_r      <= 1'b0;
      v_e1_r      <= 1'b0;
      v_e2_r      <= 1'b0;
      v_e3_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_s1_r      <= in_valid;
      v_s2_r      <= v_s1_r;
      v_s3_r      <= v_s2_r;
      v_s4_r      <= v_s3_r;
      v_s5_r      <= v_s4_r;
      v_s6_r      <= v_s5_r;
      v_s7_r      <= v_s6_r;
      v_s8_r      <= v_s7_r;
      v_s9_r      <= v_s8_r;
      v_e1_r      <= div_v;
      v_e2_r      <= v_e1_r;
      v_e3_r      <= v_e2_r;
      out_valid_r <= v_e3_r;
    end
  end

  // temperature: first products
  assign dt1 = $signed({1'b0, in_data.raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign dt2 = $signed({1'b0, in_data.raw_temperature[19:4]}) - $signed({1'b0, t1});

  always_ff @(posedge clk) begin
    if (en) begin
      ta_s1_r   <= dt1 * t2;
      dd_s1_r   <= dt2 * dt2;
      adcp_s1_r <= in_data.raw_pressure;
    end
  end

  // temperature: second-order term
  assign ddsh = 22'(dd_s1_r >>> 12);

  always_ff @(posedge clk) begin
    if (en) begin
      at_s2_r   <= 23'(ta_s1_r >>> 11);
      bt_s2_r   <= ddsh * t3;
      adcp_s2_r <= adcp_s1_r;
    end
  end

  // fine temperature
  always_ff @(posedge clk) begin
    if (en) begin
      tf_s3_r   <= 32'(at_s2_r) + 32'(bt_s2_r >>> 14);
      adcp_s3_r <= adcp_s2_r;
    end
  end

  // centidegrees with saturation; pressure offset term
  assign tc_w  = 35'(tf_s3_r) * 35'sd5 + 35'(ptc_pkg::TcRound);
  assign tc_sh = 27'(tc_w >>> 8);

  always_comb begin
    if (tc_sh > 27'(ptc_pkg::TcMax)) begin
      tc_sat = 24'(ptc_pkg::TcMax);
    end else if (tc_sh < 27'(ptc_pkg::TcMin)) begin
      tc_sat = 24'(ptc_pkg::TcMin);
    end else begin
      tc_sat = 24'(tc_sh);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tc_s4_r   <= tc_sat;
      tf_s4_r   <= tf_s3_r;
      a_s4_r    <= 64'(tf_s3_r) - 64'(ptc_pkg::TfOffset);
      adcp_s4_r <= adcp_s3_r;
    end
  end

  // first pressure products
  ptc_mul64 u_mul_aa  (.clk(clk), .en(en), .a(a_s4_r), .b(a_s4_r), .p(aa_s5));
  ptc_mul64 u_mul_ap5 (.clk(clk), .en(en), .a(a_s4_r), .b(p5x),    .p(ap5_s5));
  ptc_mul64 u_mul_ap2 (.clk(clk), .en(en), .a(a_s4_r), .b(p2x),    .p(ap2_s5));

  always_ff @(posedge clk) begin
    if (en) begin
      tc_s5_r   <= tc_s4_r;
      tf_s5_r   <= tf_s4_r;
      adcp_s5_r <= adcp_s4_r;
    end
  end

  // squared terms
  ptc_mul64 u_mul_aap6 (.clk(clk), .en(en), .a(aa_s5), .b(p6x), .p(aap6_s6));
  ptc_mul64 u_mul_aap3 (.clk(clk), .en(en), .a(aa_s5), .b(p3x), .p(aap3_s6));

  always_ff @(posedge clk) begin
    if (en) begin
      bpart_s6_r <= (ap5_s5 << 17) + (p4x << 35);
      ap2sh_s6_r <= ap2_s5 << 12;
      tc_s6_r    <= tc_s5_r;
      tf_s6_r    <= tf_s5_r;
      adcp_s6_r  <= adcp_s5_r;
    end
  end

  // offset sum and sensitivity sum
  assign aap3_sh = $signed(aap3_s6) >>> 8;

  always_ff @(posedge clk) begin
    if (en) begin
      b_s7_r    <= aap6_s6 + bpart_s6_r;
      x_s7_r    <= aap3_sh + ap2sh_s6_r + (64'd1 << ptc_pkg::OffsetShift);
      tc_s7_r   <= tc_s6_r;
      tf_s7_r   <= tf_s6_r;
      adcp_s7_r <= adcp_s6_r;
    end
  end

  // divisor product and dividend
  ptc_mul64 u_mul_p1 (.clk(clk), .en(en), .a(x_s7_r), .b({48'd0, p1}), .p(m_s8));

  assign pr = 64'(ptc_pkg::PressBase) - {44'd0, adcp_s7_r};

  always_ff @(posedge clk) begin
    if (en) begin
      n_s8_r  <= (pr << ptc_pkg::PressShift) - b_s7_r;
      tc_s8_r <= tc_s7_r;
      tf_s8_r <= tf_s7_r;
    end
  end

  // scale dividend, form divisor and its zero flag
  ptc_mul64 u_mul_scale (
    .clk(clk), .en(en), .a(n_s8_r), .b(64'(ptc_pkg::DivScale)), .p(nn_s9)
  );

  assign mshift = $signed(m_s8) >>> ptc_pkg::DivShift;

  always_ff @(posedge clk) begin
    if (en) begin
      den_s9_r         <= mshift;
      side_s9_r.tc     <= tc_s8_r;
      side_s9_r.tf     <= tf_s8_r;
      side_s9_r.pvalid <= (mshift != 64'd0);
    end
  end

  ptc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (v_s9_r),
    .num      (nn_s9),
    .den      (den_s9_r),
    .side_in  (side_s9_r),
    .out_v    (div_v),
    .quot     (div_q),
    .side_out (div_side)
  );

  // correction products
  assign qs = $signed(div_q) >>> 13;

  ptc_mul64 u_mul_p9 (.clk(clk), .en(en), .a(qs),    .b(p9x), .p(ps_e1));
  ptc_mul64 u_mul_p8 (.clk(clk), .en(en), .a(div_q), .b(p8x), .p(pb_e1));

  always_ff @(posedge clk) begin
    if (en) begin
      qs_e1_r   <= qs;
      q_e1_r    <= div_q;
      side_e1_r <= div_side;
    end
  end

  ptc_mul64 u_mul_sq (.clk(clk), .en(en), .a(ps_e1), .b(qs_e1_r), .p(a_e2));

  always_ff @(posedge clk) begin
    if (en) begin
      pb_e2_r   <= pb_e1;
      q_e2_r    <= q_e1_r;
      side_e2_r <= side_e1_r;
    end
  end

  // accumulate corrections
  assign a_sh  = $signed(a_e2) >>> 25;
  assign pb_sh = $signed(pb_e2_r) >>> 19;

  always_ff @(posedge clk) begin
    if (en) begin
      sum_e3_r  <= q_e2_r + a_sh + pb_sh;
      side_e3_r <= side_e2_r;
    end
  end

  // final scaling and clamp to the unsigned 32-bit range
  assign sum_sh = $signed(sum_e3_r) >>> 8;
  assign res    = sum_sh + (p7x << 4);

  always_comb begin
    if (res[63]) begin
      press_sat = 32'd0;
    end else if (res[63:32] != 32'd0) begin
      press_sat = 32'hFFFF_FFFF;
    end else begin
      press_sat = res[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.temperature_centideg <= side_e3_r.tc;
      out_data_r.fine_temperature     <= side_e3_r.tf;
      out_data_r.pressure_q24_8       <= side_e3_r.pvalid ? press_sat : 32'd0;
      out_data_r.pressure_valid       <= side_e3_r.pvalid;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // an invalid pressure always reads as zero
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.pressure_valid |-> out_data_r.pressure_q24_8 == 32'd0)
    else $error("invalid pressure not zero");

  // input is held back only by a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r && out_stall)
    else $error("input stalled without a held result");

  // a held pipeline keeps its occupancy
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_s5_r) && $stable(v_e2_r))
    else $error("pipeline moved while held");

  // a zero divisor clears the pressure flag
  a_zero_div: assert property (@(posedge clk) disable iff (!rst_n)
    en && v_s8_r && mshift == 64'd0 |=> !side_s9_r.pvalid)
    else $error("zero divisor not flagged");

endmodule

// ===== dv/pressure_temperature_compensation_test.sv =====
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_test: self-checking compensation bench
// Drives pairs of raw readings under several calibration settings, predicts
// each result with an independent 64-bit model and checks every field.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Latency = 79;
  localparam longint CycleLimit = 400000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  ptc_pkg::in_t         in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  ptc_pkg::out_t        out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [ptc_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [63:0]          cfg_data = '0;

  // calibration copy held by the predictor
  logic [47:0] cal_temp;
  logic [63:0] cal_pa, cal_pb;
  logic [15:0] cal_p9;

  ptc_pkg::out_t expected_results[$];
  int     error_count = 0;
  longint cycle_count = 0;
  bit     sender_idle_en = 1'b1;
  bit     receiver_idle_en = 1'b1;
  bit     hold_off = 1'b0;
  int     stall_left = 0;

  pressure_temperature_compensation dut (.*);

  always #4 clk = ~clk;

  // guard the run length
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAIL pressure_temperature_compensation");
      $finish;
    end
  end

  function automatic logic signed [63:0] s16(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  // compensate one pair of readings
  function automatic ptc_pkg::out_t compensate(ptc_pkg::in_t item);
    ptc_pkg::out_t r;
    logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [63:0] adc_t, adc_p, a, b, d, tf, p, tc, q;
    t1 = {48'd0, cal_temp[15:0]};
    t2 = s16(cal_temp[31:16]);
    t3 = s16(cal_temp[47:32]);
    p1 = {48'd0, cal_pa[15:0]};
    p2 = s16(cal_pa[31:16]);
    p3 = s16(cal_pa[47:32]);
    p4 = s16(cal_pa[63:48]);
    p5 = s16(cal_pb[15:0]);
    p6 = s16(cal_pb[31:16]);
    p7 = s16(cal_pb[47:32]);
    p8 = s16(cal_pb[63:48]);
    p9 = s16(cal_p9);
    adc_t = {44'd0, item.raw_temperature};
    adc_p = {44'd0, item.raw_pressure};
    // temperature stage
    a = (((adc_t >>> 3) - (t1 <<< 1)) * t2) >>> 11;
    d = (adc_t >>> 4) - t1;
    b = (((d * d) >>> 12) * t3) >>> 14;
    tf = a + b;
    tc = (tf * 5 + 128) >>> 8;
    if (tc > ptc_pkg::TcMax) tc = ptc_pkg::TcMax;
    if (tc < ptc_pkg::TcMin) tc = ptc_pkg::TcMin;
    r.temperature_centideg = tc[23:0];
    r.fine_temperature = tf[31:0];
    r.pressure_q24_8 = '0;
    r.pressure_valid = 1'b0;
    // pressure stage, wrapping 64-bit
    a = tf - 128000;
    b = a * a * p6;
    b = b + ((a * p5) <<< 17);
    b = b + (p4 <<< 35);
    a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
    a = (((64'sd1 <<< 47) + a) * p1) >>> 33;
    if (a != 0) begin
      p = 1048576 - adc_p;
      q = ((p <<< 31) - b) * 3125;
      if (a == -1) p = -q;
      else p = q / a;
      a = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
      b = (p8 * p) >>> 19;
      p = ((p + a + b) >>> 8) + (p7 <<< 4);
      if (p < 0) r.pressure_q24_8 = '0;
      else if (p > 64'sh0FFFF_FFFF) r.pressure_q24_8 = '1;
      else r.pressure_q24_8 = p[31:0];
      r.pressure_valid = 1'b1;
    end
    return r;
  endfunction

  // write one calibration register while idle; the caller drops valid
  task automatic write_calibration(ptc_pkg::cfg_idx_t idx, logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ptc_pkg::CFG_TEMP:     cal_temp = value[47:0];
      ptc_pkg::CFG_PRESS_A:  cal_pa = value;
      ptc_pkg::CFG_PRESS_B:  cal_pb = value;
      ptc_pkg::CFG_PRESS_P9: cal_p9 = value[15:0];
      default: ;
    endcase
  endtask

  task automatic set_calibration(logic [47:0] t, logic [63:0] pa, logic [63:0] pb,
                                 logic [15:0] p9);
    write_calibration(ptc_pkg::CFG_TEMP, {16'd0, t});
    write_calibration(ptc_pkg::CFG_PRESS_A, pa);
    write_calibration(ptc_pkg::CFG_PRESS_B, pb);
    write_calibration(ptc_pkg::CFG_PRESS_P9, {48'd0, p9});
    cfg_valid <= 1'b0;
  endtask

  // offer one transaction, with an optional random gap first; valid stays
  // high after acceptance until the next gap or the drain
  task automatic send_reading(logic [19:0] rt, logic [19:0] rp);
    ptc_pkg::in_t item;
    item.raw_temperature = rt;
    item.raw_pressure = rp;
    if (sender_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    expected_results.push_back(compensate(item));
    do @(posedge clk); while (in_stall);
  endtask

  // drop valid and wait for every outstanding result
  task automatic drain;
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (Latency + 5) @(posedge clk);
  endtask

  // stall the result channel in random bursts, or for a long hold-off
  always @(posedge clk) begin
    if (hold_off) begin
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else if (receiver_idle_en && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 8);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // check each result transaction against the oldest expectation
  always @(posedge clk) begin
    ptc_pkg::out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction");
        error_count++;
      end else begin
        e = expected_results.pop_front();
        if (out_data.temperature_centideg !== e.temperature_centideg) begin
          $error("temperature_centideg exp %0d got %0d",
                 e.temperature_centideg, out_data.temperature_centideg);
          error_count++;
        end
        if (out_data.fine_temperature !== e.fine_temperature) begin
          $error("fine_temperature exp %0d got %0d",
                 e.fine_temperature, out_data.fine_temperature);
          error_count++;
        end
        if (out_data.pressure_q24_8 !== e.pressure_q24_8) begin
          $error("pressure_q24_8 exp %h got %h",
                 e.pressure_q24_8, out_data.pressure_q24_8);
          error_count++;
        end
        if (out_data.pressure_valid !== e.pressure_valid) begin
          $error("pressure_valid exp %b got %b",
                 e.pressure_valid, out_data.pressure_valid);
          error_count++;
        end
      end
    end
  end

  // zero calibration: divisor zero, pressure invalid
  task automatic test_reset_calibration;
    send_reading(20'h00000, 20'h00000);
    send_reading(20'hFFFFF, 20'hFFFFF);
    drain();
  endtask

  // typical sensor words, extremes of the readings and register extremes
  task automatic test_directed;
    set_calibration({16'd50, 16'd26435, 16'd27504}, {16'd2855, 16'd140, 16'hD4CB, 16'd36477},
                    {16'h3B10, 16'hFFF9, 16'hFF85, 16'h0000}, 16'd6000);
    send_reading(20'd519888, 20'd415148);
    send_reading(20'h00000, 20'h00000);
    send_reading(20'hFFFFF, 20'hFFFFF);
    send_reading(20'h00000, 20'hFFFFF);
    send_reading(20'hFFFFF, 20'h00000);
    send_reading(20'h80000, 20'h80000);
    drain();
    set_calibration(48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                    16'hFFFF);
    send_reading(20'h00000, 20'hFFFFF);
    send_reading(20'hFFFFF, 20'h00000);
    drain();
    set_calibration({16'h8000, 16'h7FFF, 16'hFFFF}, {16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF},
                    {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, 16'h8000);
    send_reading(20'h00000, 20'h00000);
    send_reading(20'hFFFFF, 20'hFFFFF);
    send_reading(20'h55555, 20'hAAAAA);
    drain();
  endtask

  // random readings under random and realistic calibrations
  task automatic test_random(int phases, int per_phase);
    for (int ph = 0; ph < phases; ph++) begin
      if (ph % 2 == 0)
        set_calibration({$urandom(), 16'($urandom())}, {$urandom(), $urandom()},
                        {$urandom(), $urandom()}, 16'($urandom()));
      else
        set_calibration({16'($urandom_range(0, 100)), 16'($urandom_range(25000, 28000)),
                         16'($urandom_range(26000, 28000))},
                        {16'($urandom_range(0, 40000)), 16'($urandom_range(0, 300)),
                         16'($urandom_range(54000, 55000)), 16'($urandom_range(30000, 40000))},
                        {16'($urandom_range(15000, 16000)), 16'($urandom_range(65520, 65535)),
                         16'($urandom_range(65400, 65535)), 16'($urandom_range(0, 100))},
                        16'($urandom_range(5000, 7000)));
      repeat (per_phase)
        send_reading(20'($urandom()), 20'($urandom()));
      drain();
    end
  endtask

  // hold the receiver off so the pipeline fills and stalls its input; the
  // sender cannot finish before the hold-off ends, so the drain drops valid
  task automatic test_back_pressure;
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      repeat (150) send_reading(20'($urandom()), 20'($urandom()));
    join
    drain();
  endtask

  // back-to-back traffic with no idling
  task automatic test_full_rate;
    sender_idle_en = 1'b0;
    receiver_idle_en = 1'b0;
    repeat (150) send_reading(20'($urandom()), 20'($urandom()));
    drain();
  endtask

  initial begin
    cal_temp = '0;
    cal_pa = '0;
    cal_pb = '0;
    cal_p9 = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_calibration();
    test_directed();
    test_random(8, 90);
    test_back_pressure();
    test_full_rate();
    if (error_count == 0) $display("PASS pressure_temperature_compensation");
    else $display("FAIL pressure_temperature_compensation");
    $finish;
  end

endmodule
